// ----- rtl/cbal_pkg.sv -----
package cbal_pkg;

  // Actuator count and derived request mask
  localparam int unsigned ACTUATORS  = 16;
  localparam logic [15:0] VALID_MASK = 16'((32'd1 << ACTUATORS) - 32'd1);

  // Draw table layout: four 16-bit draws per 64-bit cost word
  localparam int unsigned DRAW_W         = 16;
  localparam int unsigned DRAWS_PER_WORD = 4;
  localparam int unsigned COST_WORDS     = 4;
  localparam int unsigned WORD_IDX_W     = 2;
  localparam int unsigned COST_W         = DRAW_W * DRAWS_PER_WORD;

  // Current and remaining-budget widths
  localparam int unsigned CUR_W = 20;
  localparam int unsigned REM_W = 21;
  localparam logic [REM_W-1:0] UNLIMITED_REMAIN = REM_W'(1048575);

  // Command codes
  localparam logic [1:0] CMD_ACQUIRE     = 2'd0;
  localparam logic [1:0] CMD_RELEASE     = 2'd1;
  localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COST0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COST3  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load;      // latch a new request
    logic                  accum;     // add one cost word's selected draws
    logic [WORD_IDX_W-1:0] word_idx;  // cost word being summed
    logic                  commit;    // update state and load the result
  } ctrl_cmd_t;

endpackage

// ----- rtl/current_budget_actuator_lock.sv -----
// Requests are taken one at a time: a new request is accepted only once the last
// one has been committed. The draw sum adds one cost word (four draws) per cycle,
//   then a commit step updates state; the commit waits while a stalled result is held.
// A finished result waits in the output register while the next request runs.
// Reset (rst_ni low, asynchronous): nothing held, zero charge, budget and
//   draw table cleared, no result pending.
module current_budget_actuator_lock (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [15:0]                         actuator_mask_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                granted_o,
  output logic [15:0]                         held_mask_o,
  output logic [cbal_pkg::CUR_W-1:0]          total_draw_o,
  output logic signed [cbal_pkg::REM_W-1:0]   remaining_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbal_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cbal_pkg::COST_W-1:0]         cfg_data_i
);

  cbal_pkg::ctrl_cmd_t cmd;

  // Configuration must be written only while idle; this block does not enforce it, so always take the transfer.
  assign cfg_ready_o = 1'b1;

  // Sequencer: accept, sum the four cost words, then commit the result
  cbal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Held set, charge, budget and draw table, plus the result register
  cbal_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .command_i       (command_i),
    .actuator_mask_i (actuator_mask_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .granted_o       (granted_o),
    .held_mask_o     (held_mask_o),
    .total_draw_o    (total_draw_o),
    .remaining_o     (remaining_o)
  );

endmodule

// ----- rtl/cbal_ctrl.sv -----
module cbal_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbal_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [cbal_pkg::WORD_IDX_W-1:0]     cnt_q, cnt_d;
  logic                                out_valid_q, out_valid_d;
  logic                                accept;
  logic                                out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o.load     = 1'b0;
    cmd_o.accum    = 1'b0;
    cmd_o.word_idx = cnt_q;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.accum = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == cbal_pkg::WORD_IDX_W'(cbal_pkg::COST_WORDS - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/cbal_datapath.sv -----
module cbal_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cbal_pkg::ctrl_cmd_t                 cmd_i,
  input  logic [1:0]                          command_i,
  input  logic [15:0]                         actuator_mask_i,
  input  logic                                cfg_we_i,
  input  logic [cbal_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cbal_pkg::COST_W-1:0]         cfg_data_i,
  output logic                                granted_o,
  output logic [15:0]                         held_mask_o,
  output logic [cbal_pkg::CUR_W-1:0]          total_draw_o,
  output logic signed [cbal_pkg::REM_W-1:0]   remaining_o
);

  logic [cbal_pkg::CUR_W-1:0]  budget_q;
  logic [cbal_pkg::COST_W-1:0] cost_q [cbal_pkg::COST_WORDS];

  logic [1:0]                  cmd_q;
  logic [15:0]                 req_q;
  logic [cbal_pkg::CUR_W-1:0]  acc_q, acc_d;
  logic [15:0]                 held_q, held_d;
  logic [cbal_pkg::CUR_W-1:0]  charged_q, charged_d;
  logic                        granted_q, granted_d;
  logic [cbal_pkg::REM_W-1:0]  remain_q, remain_d;

  logic [15:0]                 work_mask;
  logic [3:0]                  sel_bits;
  logic [cbal_pkg::COST_W-1:0] word;
  logic [cbal_pkg::CUR_W-1:0]  word_sum;
  logic [cbal_pkg::CUR_W:0]    acq_total;
  logic                        budget_set;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      for (int i = 0; i < cbal_pkg::COST_WORDS; i++) begin
        cost_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cbal_pkg::CFG_BUDGET: budget_q  <= cfg_data_i[cbal_pkg::CUR_W-1:0];
        cbal_pkg::CFG_COST0:  cost_q[0] <= cfg_data_i;
        cbal_pkg::CFG_COST1:  cost_q[1] <= cfg_data_i;
        cbal_pkg::CFG_COST2:  cost_q[2] <= cfg_data_i;
        cbal_pkg::CFG_COST3:  cost_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Acquire sums draws not yet held; release sums draws actually held
  assign work_mask = (cmd_q == cbal_pkg::CMD_ACQUIRE) ? (req_q & ~held_q) : (req_q & held_q);
  assign sel_bits  = work_mask[{cmd_i.word_idx, 2'b00} +: 4];
  assign word      = cost_q[cmd_i.word_idx];

  always_comb begin
    word_sum = '0;
    for (int k = 0; k < cbal_pkg::DRAWS_PER_WORD; k++) begin
      if (sel_bits[k]) begin
        word_sum = word_sum
                 + cbal_pkg::CUR_W'(word[k*cbal_pkg::DRAW_W +: cbal_pkg::DRAW_W]);
      end
    end
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = '0;
    end else if (cmd_i.accum) begin
      acc_d = acc_q + word_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      req_q <= actuator_mask_i & cbal_pkg::VALID_MASK;
    end
    acc_q <= acc_d;
  end

  assign budget_set = (budget_q != '0);
  assign acq_total  = {1'b0, charged_q} + {1'b0, acc_q};

  always_comb begin
    held_d    = held_q;
    charged_d = charged_q;
    granted_d = 1'b0;
    case (cmd_q)
      cbal_pkg::CMD_ACQUIRE: begin
        if (!(budget_set && (acq_total > {1'b0, budget_q}))) begin
          granted_d = 1'b1;
          held_d    = held_q | req_q;
          if (budget_set) begin
            charged_d = acq_total[cbal_pkg::CUR_W-1:0];
          end
        end
      end
      cbal_pkg::CMD_RELEASE: begin
        granted_d = 1'b1;
        held_d    = held_q & ~req_q;
        charged_d = (acc_q >= charged_q) ? '0 : (charged_q - acc_q);
      end
      cbal_pkg::CMD_RELEASE_ALL: begin
        granted_d = 1'b1;
        held_d    = '0;
        charged_d = '0;
      end
      default: ;
    endcase
    remain_d = budget_set ? ({1'b0, budget_q} - {1'b0, charged_d})
                          : cbal_pkg::UNLIMITED_REMAIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      charged_q <= '0;
    end else if (cmd_i.commit) begin
      held_q    <= held_d;
      charged_q <= charged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      remain_q  <= remain_d;
    end
  end

  assign granted_o    = granted_q;
  assign held_mask_o  = held_q;
  assign total_draw_o = charged_q;
  assign remaining_o  = remain_q;

endmodule

// ----- sim/tb_current_budget_actuator_lock.sv -----
`timescale 1ns / 100ps

module tb_current_budget_actuator_lock;
  import cbal_pkg::*;

  // One request as it crosses the request channel
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] mask;
  } request_t;

  // One grant report as it leaves the result channel
  typedef struct packed {
    logic             granted;
    logic [15:0]      held;
    logic [CUR_W-1:0] draw;
    logic [REM_W-1:0] remaining;
  } grant_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request channel, driven at the rising edge
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_ACQUIRE;
  logic [15:0] actuator_mask = '0;

  // Result channel
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    granted;
  logic [15:0]             held_mask;
  logic [CUR_W-1:0]        total_draw;
  logic signed [REM_W-1:0] remaining;

  // Configuration write channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BUDGET;
  logic [COST_W-1:0]    cfg_data = '0;

  // Shadow copy of the lock: configuration and state
  logic [CUR_W-1:0]  budget_q = '0;
  logic [COST_W-1:0] cost_q [COST_WORDS];
  logic [15:0]       held_q = '0;
  logic [CUR_W-1:0]  charge_q = '0;

  request_t      pending_requests [$];
  grant_report_t expected_reports [$];
  grant_report_t want;
  int            fail_count = 0;
  int            cycle_count = 0;
  logic          hold_off = 1'b0;
  logic          took;

  current_budget_actuator_lock dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .actuator_mask_i (actuator_mask),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .granted_o       (granted),
    .held_mask_o     (held_mask),
    .total_draw_o    (total_draw),
    .remaining_o     (remaining),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // 4 ns clock: 2 ns high, 2 ns low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Sum the configured draws of every actuator named in the mask.
  function automatic logic [31:0] draw_sum(logic [15:0] mask);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      if (mask[i]) s += 32'(cost_q[i / 4][16 * (i % 4) +: 16]);
    end
    return s;
  endfunction

  // Advance the shadow lock by one request and return the report it gives.
  function automatic grant_report_t apply_request(request_t r);
    logic [15:0]   req;
    logic [15:0]   moved;
    logic [31:0]   need;
    grant_report_t rep;
    req = r.mask & VALID_MASK;
    rep.granted = 1'b0;
    case (r.command)
      CMD_ACQUIRE: begin
        moved = req & ~held_q;
        need = draw_sum(moved);
        // All or nothing: deny when a set budget would be exceeded
        if (budget_q == '0 || 32'(charge_q) + need <= 32'(budget_q)) begin
          if (budget_q != '0) charge_q = charge_q + need[CUR_W-1:0];
          held_q |= req;
          rep.granted = 1'b1;
        end
      end
      CMD_RELEASE: begin
        // Only held actuators give back their draw; saturate at zero
        moved = req & held_q;
        need = draw_sum(moved);
        held_q &= ~moved;
        charge_q = (need >= 32'(charge_q)) ? '0 : charge_q - need[CUR_W-1:0];
        rep.granted = 1'b1;
      end
      CMD_RELEASE_ALL: begin
        held_q = '0;
        charge_q = '0;
        rep.granted = 1'b1;
      end
      default: ;  // unused command: state unchanged, not granted
    endcase
    rep.held = held_q;
    rep.draw = charge_q;
    rep.remaining = (budget_q == '0) ? UNLIMITED_REMAIN
                                     : REM_W'({1'b0, budget_q} - {1'b0, charge_q});
    return rep;
  endfunction

  // Random idle roll shared by both sides; no idling inside the calm window.
  function automatic logic idle_roll();
    if (cycle_count >= 9000 && cycle_count < 12000) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  // Request driver: hold a stalled payload, otherwise offer the next pending one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_reports.push_back(apply_request(pending_requests.pop_front()));
      end
      if (in_valid && !took) begin
        // hold the stalled transfer as it is
      end else if (pending_requests.size() != 0 && !idle_roll()) begin
        in_valid      <= 1'b1;
        command       <= pending_requests[0].command;
        actuator_mask <= pending_requests[0].mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare every transfer against the oldest expected report.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, granted);
            fail_count++;
          end
          if (held_mask !== want.held) begin
            $error("held_mask: expected %h, actual %h", want.held, held_mask);
            fail_count++;
          end
          if (total_draw !== want.draw) begin
            $error("total_draw: expected %0d, actual %0d", want.draw, total_draw);
            fail_count++;
          end
          if (remaining !== $signed(want.remaining)) begin
            $error("remaining: expected %0d, actual %0d", $signed(want.remaining),
                   remaining);
            fail_count++;
          end
        end
      end
      out_stall <= hold_off || idle_roll();
    end
  end

  // Long receiver hold-off once traffic is queued, so the lock backs up into its input.
  initial begin
    while (cycle_count < 5000 || pending_requests.size() < 20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Write one register and mirror it into the shadow copy on its transfer.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BUDGET: budget_q = data[CUR_W-1:0];
      CFG_COST0:  cost_q[0] = data;
      CFG_COST1:  cost_q[1] = data;
      CFG_COST2:  cost_q[2] = data;
      CFG_COST3:  cost_q[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_cost_table(logic [63:0] w0, logic [63:0] w1,
                                 logic [63:0] w2, logic [63:0] w3);
    write_reg(CFG_COST0, w0);
    write_reg(CFG_COST1, w1);
    write_reg(CFG_COST2, w2);
    write_reg(CFG_COST3, w3);
  endtask

  task automatic push_request(logic [1:0] cmd, logic [15:0] mask);
    request_t r;
    r.command = cmd;
    r.mask = mask;
    pending_requests.push_back(r);
  endtask

  // Wait for every request to resolve, then let the pipeline settle.
  task automatic drain();
    while (pending_requests.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One random phase: pick a draw table and budget, then mostly well-formed traffic.
  task automatic run_random_phase(int budget_style, int draw_style, int count);
    logic [63:0] words [4];
    logic [15:0] draw;
    logic [19:0] budget;
    logic [15:0] mask;
    int          pick;
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 4; k++) begin
        case (draw_style)
          0:       draw = 16'($urandom_range(300));
          1:       draw = 16'($urandom);
          2:       draw = 16'hFFFF;
          default: draw = 16'h0000;
        endcase
        words[w][16 * k +: 16] = draw;
      end
    end
    load_cost_table(words[0], words[1], words[2], words[3]);
    case (budget_style)
      0:       budget = 20'd0;
      1:       budget = 20'($urandom_range(2000, 1));
      2:       budget = 20'hFFFFF;
      3:       budget = 20'd1;
      default: budget = 20'($urandom);
    endcase
    // Upper data bits are don't-care for the budget; toggle them anyway
    write_reg(CFG_BUDGET, {$urandom, 12'($urandom), budget});
    repeat (count) begin
      mask = '0;
      repeat ($urandom_range(3, 1)) mask[$urandom_range(15)] = 1'b1;
      pick = $urandom_range(99);
      if (pick < 50)      push_request(CMD_ACQUIRE, mask);
      else if (pick < 78) push_request(CMD_RELEASE, mask);
      else if (pick < 84) push_request(CMD_RELEASE_ALL, 16'($urandom));
      else if (pick < 88) push_request(2'd3, 16'($urandom));
      else                push_request(2'($urandom_range(2)), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: budget of 1000 mA with a known draw table
    load_cost_table({16'd400, 16'd300, 16'd200, 16'd100},
                    {16'hFFFF, 16'd0, 16'd50, 16'd25},
                    {4{16'd10}},
                    {16'd7, 16'd5, 16'd3, 16'd1});
    write_reg(CFG_BUDGET, 64'd1000);
    push_request(CMD_ACQUIRE, 16'h0001);      // charge 100
    push_request(CMD_ACQUIRE, 16'h0001);      // already held, no second charge
    push_request(CMD_ACQUIRE, 16'h000E);      // fills the budget exactly
    push_request(CMD_ACQUIRE, 16'h0010);      // 25 over, denied
    push_request(CMD_RELEASE, 16'h0100);      // not held, nothing changes
    push_request(CMD_RELEASE, 16'h0003);
    push_request(2'd3, 16'hFFFF);             // unused command
    push_request(CMD_ACQUIRE, 16'h0000);      // empty set
    push_request(CMD_RELEASE_ALL, 16'h5A5A);
    push_request(CMD_ACQUIRE, 16'hFFFF);      // far over budget, denied
    push_request(CMD_ACQUIRE, 16'h8000);
    push_request(CMD_RELEASE, 16'hFFFF);
    drain();

    // Directed: unlimited budget, nothing charged, release saturates
    write_reg(CFG_BUDGET, 64'd0);
    push_request(CMD_ACQUIRE, 16'hFFFF);
    push_request(CMD_RELEASE, 16'h0001);
    push_request(CMD_RELEASE_ALL, 16'h0000);
    drain();

    // Directed: widest draws under the widest budget
    load_cost_table('1, '1, '1, '1);
    write_reg(CFG_BUDGET, 64'hFFFFF);
    push_request(CMD_ACQUIRE, 16'h000F);
    push_request(CMD_ACQUIRE, 16'hFFFF);      // lands 15 mA under the top
    push_request(CMD_ACQUIRE, 16'hFFFF);      // all held, granted again
    drain();

    // Directed: budget lowered below the charge, remaining goes negative
    write_reg(CFG_BUDGET, 64'd5000);
    push_request(CMD_ACQUIRE, 16'h0000);      // denied, nothing fits
    push_request(CMD_RELEASE, 16'h0001);
    push_request(2'd3, 16'h0000);
    push_request(CMD_RELEASE_ALL, 16'hFFFF);
    drain();

    // Random phases, sweeping budget and draw-table shapes
    for (int p = 0; p < 8; p++) run_random_phase(p % 5, p % 4, 250);

    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("current_budget_actuator_lock test passed");
    end else begin
      $display("current_budget_actuator_lock test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("current_budget_actuator_lock test failed");
    $finish;
  end

endmodule
